>>> rtl/core/sfpg_pkg.sv
package sfpg_pkg;

	localparam int GAIN_W      = 15;
	localparam int PAN_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int FADE_W      = 24;
	localparam int FACTOR_NUM_W = 18;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 15'd16384;
	localparam logic [GAIN_W-1:0] MAX_GAIN   = 15'd24576;

	localparam int ROUND_SHIFT   = 14;
	localparam int ROUND_BIAS    = 8192;
	localparam int CURVE_DIVISOR = 21;
	// 0.7 in Q2.14 times ten, plus half of the divisor for rounding
	localparam int BOOST_BIAS    = 114693;
	localparam int BOOST_SLOPE   = 3;
	// numerator is halved, then divided by 5 as a reciprocal product
	localparam int BOOST_SHIFT   = 19;
	localparam int BOOST_RECIP   = ((1 << BOOST_SHIFT) + 4) / 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN         = 3'd0,
		REG_PAN          = 3'd1,
		REG_NO_SOFT_CLIP = 3'd2,
		REG_FADE_SAMPLES = 3'd3,
		REG_FADE_TARGET  = 3'd4,
		REG_TERMINATE    = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RMUL,
		S_RDIV,
		S_RWAIT,
		S_MUL,
		S_MRES,
		S_CMUL,
		S_CRES,
		S_FMUL,
		S_FRES,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_GAIN_L,
		OP_GAIN_R,
		OP_PAN,
		OP_BOOST
	} op_t;

	function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g,
		input logic no_soft);
		logic [GAIN_W-1:0] r;
		r = g;
		if (r > MAX_GAIN) r = MAX_GAIN;
		if (no_soft && (r > UNITY_GAIN)) r = UNITY_GAIN;
		return r;
	endfunction

endpackage

>>> rtl/core/sfpg_if.sv
interface sfpg_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source(output valid, output left_in, output right_in, input ready);
	modport sink(input valid, input left_in, input right_in, output ready);
endinterface

interface sfpg_out_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          last;

	modport source(output valid, output left_out, output right_out, output last, input ready);
	modport sink(input valid, input left_out, input right_out, input last, output ready);
endinterface

>>> rtl/core/sfpg_mul.sv
module sfpg_mul #(
	parameter int AW = 25,
	parameter int BW = 15
) (
	input  logic             clk,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	input  logic             round_en,
	output logic [AW+BW-1:0] product
);

	localparam int PW = AW + BW;

	logic [PW-1:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= PW'(a) * PW'(b)
			+ (round_en ? PW'(sfpg_pkg::ROUND_BIAS) : PW'(0));
	end

	assign product = product_q;

endmodule

>>> rtl/core/sfpg_div.sv
module sfpg_div #(
	parameter int DIVW = 24,
	parameter int QW   = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIVW+QW-1:0] dividend,
	input  logic [DIVW-1:0]    divisor,
	output logic               done,
	output logic [QW-1:0]      quotient
);

	localparam int CW = $clog2(QW + 1);

	logic [DIVW-1:0] rem_q;
	logic [QW-1:0]   quo_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DIVW:0]   trial;
	logic [DIVW:0]   trial_sub;
	logic            fits;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial     = {rem_q, quo_q[QW-1]};
		trial_sub = trial - {1'b0, divisor};
		fits      = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(QW);
			rem_q  <= dividend[DIVW+QW-1:QW];
			quo_q  <= dividend[QW-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIVW-1:0] : trial[DIVW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/core/stereo_fade_pan_gain_unit.sv
// Stereo gain, linear fade and pan with optional soft amplify curve.
// samples: one stereo pair per transfer (valid/ready). results: one processed
// pair per transfer, with last set on the pair that ends a terminating fade.
// Once that pair is out, later sample transfers are taken and dropped.
// Configuration: wr_en/wr_index/wr_data, one register per cycle, no wait.
// One pair at a time: a new pair is taken only once the last has left the
// processing states. A fade step, pan, the soft curve at every gain stage and
// the edge boost each lengthen a plain pass.
// The fade step is the long part: the divider gives one quotient bit per
// cycle. One shared multiplier does every gain product, and the curve and boost
// divisions by constants as reciprocal products.
// The result sits in an output register; the next pair is accepted while it
// waits, and processing stalls in its last cycle until the register is free.
// Reset (arst_n low): unity gain, centre pan, soft mode, no fade, stream running,
// no result pending.
module stereo_fade_pan_gain_unit #(
	parameter int SAMPLE_BITS     = 24,
	parameter int RAMP_COUNT_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sfpg_in_if.sink                           samples,
	sfpg_out_if.source                        results,
	input  logic                              wr_en,
	input  logic [sfpg_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [sfpg_pkg::CFG_DATA_W-1:0]   wr_data
);

	localparam int GW   = sfpg_pkg::GAIN_W;
	localparam int FRAC = SAMPLE_BITS - 1;
	localparam int MW   = SAMPLE_BITS + 1;
	localparam int QW   = MW;
	localparam int RB   = RAMP_COUNT_BITS;
	localparam int AW   = (MW > RB) ? MW : RB;
	localparam int BW   = MW;
	localparam int PW   = AW + BW;
	localparam int DDW  = RB + QW;
	localparam int CURVE_SHIFT = FRAC + 5;

	localparam logic [MW-1:0] THRESH  = MW'(((64'd95 << FRAC) + 64'd50) / 64'd100);
	localparam logic [MW-1:0] LIM_NEG = MW'(1) << FRAC;
	localparam logic [MW-1:0] LIM_POS = (MW'(1) << FRAC) - MW'(1);
	localparam logic [BW-1:0] CURVE_RECIP = BW'(((64'd1 << CURVE_SHIFT)
		+ 64'(sfpg_pkg::CURVE_DIVISOR) - 64'd1) / 64'(sfpg_pkg::CURVE_DIVISOR));
	localparam logic [BW-1:0] BOOST_MULT  = BW'(sfpg_pkg::BOOST_RECIP);

	sfpg_pkg::state_t state_q, state_d;
	sfpg_pkg::op_t    op_q, op_next;
	sfpg_pkg::state_t after_op;

	// settings
	logic signed [sfpg_pkg::PAN_W-1:0] pan_q;
	logic                              nsc_q;
	logic [GW-1:0]                     fade_tgt_q;
	logic                              term_set_q;

	// gain and fade state
	logic [GW-1:0] gain_q;
	logic [GW-1:0] rstart_q;
	logic [GW-1:0] rtarget_q;
	logic [RB-1:0] rtotal_q;
	logic [RB-1:0] rremain_q;
	logic          ractive_q;
	logic          rterm_q;
	logic          stopped_q;

	// item in flight
	logic          lneg_q;
	logic          rneg_q;
	logic [MW-1:0] lm_q;
	logic [MW-1:0] rm_q;
	logic          last_q;
	logic [GW-1:0] factor_q;

	// output register
	logic                          oval_q;
	logic signed [SAMPLE_BITS-1:0] oleft_q;
	logic signed [SAMPLE_BITS-1:0] oright_q;
	logic                          olast_q;

	// shared units
	logic [AW-1:0]  mul_a;
	logic [BW-1:0]  mul_b;
	logic           mul_round;
	logic [PW-1:0]  mul_p;
	logic           div_start;
	logic [DDW-1:0] div_dividend;
	logic [RB-1:0]  div_divisor;
	logic           div_done;
	logic [QW-1:0]  div_quot;

	logic                  soft_mode;
	logic                  pan_neg;
	logic                  pan_pos;
	logic signed [16:0]    pan_x;
	logic signed [16:0]    pan_lsum;
	logic signed [16:0]    pan_rdif;
	logic signed [16:0]    pan_abs;
	logic [GW-1:0]         pan_gain;
	logic [GW-1:0]         apan;
	logic [sfpg_pkg::FACTOR_NUM_W-1:0] boost_num;
	logic                  ramp_up;
	logic [GW-1:0]         ramp_diff;
	logic [RB-1:0]         ramp_done;
	logic                  op_left;
	logic [MW-1:0]         cur_m;
	logic [GW-1:0]         op_gain;
	logic [MW-1:0]         m_res;
	logic [MW-1:0]         curve_q;
	logic [GW-1:0]         factor_d;
	logic                  curve_need;
	logic                  in_xfer;
	logic                  out_free;
	logic                  ramp_step;
	logic                  ramp_end;
	logic [RB-1:0]         fade_len;
	logic [55:0]           fade_wide;
	logic [SAMPLE_BITS:0]  lin_ext;
	logic [SAMPLE_BITS:0]  rin_ext;

	function automatic logic [SAMPLE_BITS-1:0] saturate(input logic neg, input logic [MW-1:0] m);
		logic [MW-1:0] mc;
		logic [MW-1:0] v;
		if (neg) begin
			mc = (m > LIM_NEG) ? LIM_NEG : m;
			v  = ~mc + MW'(1);
		end else begin
			mc = (m > LIM_POS) ? LIM_POS : m;
			v  = mc;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	sfpg_mul #(.AW(AW), .BW(BW)) u_mul (
		.clk      (clk),
		.a        (mul_a),
		.b        (mul_b),
		.round_en (mul_round),
		.product  (mul_p)
	);

	sfpg_div #(.DIVW(RB), .QW(QW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// datapath decode
	always_comb begin
		soft_mode = !nsc_q;
		pan_neg   = pan_q[sfpg_pkg::PAN_W-1];
		pan_pos   = !pan_neg && (pan_q != '0);
		pan_x     = {pan_q[sfpg_pkg::PAN_W-1], pan_q};
		pan_lsum  = 17'sd16384 + pan_x;
		pan_rdif  = 17'sd16384 - pan_x;
		pan_abs   = pan_neg ? -pan_x : pan_x;
		pan_gain  = pan_neg ? pan_lsum[GW-1:0] : pan_rdif[GW-1:0];
		apan      = pan_abs[GW-1:0];
		boost_num = sfpg_pkg::FACTOR_NUM_W'(sfpg_pkg::BOOST_BIAS)
			+ sfpg_pkg::FACTOR_NUM_W'(apan) * sfpg_pkg::FACTOR_NUM_W'(sfpg_pkg::BOOST_SLOPE);
		ramp_up   = rtarget_q >= rstart_q;
		ramp_diff = ramp_up ? (rtarget_q - rstart_q) : (rstart_q - rtarget_q);
		ramp_done = rtotal_q - rremain_q;
		op_left   = (op_q == sfpg_pkg::OP_GAIN_L)
			|| ((op_q == sfpg_pkg::OP_PAN) && pan_neg)
			|| ((op_q == sfpg_pkg::OP_BOOST) && pan_pos);
		cur_m     = op_left ? lm_q : rm_q;
		m_res     = mul_p[sfpg_pkg::ROUND_SHIFT +: MW];
		curve_q   = MW'(mul_p >> CURVE_SHIFT);
		factor_d  = GW'(mul_p >> sfpg_pkg::BOOST_SHIFT);
		curve_need = soft_mode && (op_q != sfpg_pkg::OP_PAN) && (m_res > THRESH);
		in_xfer   = samples.valid && samples.ready;
		out_free  = !oval_q || results.ready;
		ramp_end  = ractive_q && ((rremain_q == '0) || (rtotal_q == '0));
		ramp_step = ractive_q && !ramp_end;
		fade_wide = {32'b0, wr_data};
		fade_len  = fade_wide[RB-1:0];
		lin_ext   = {samples.left_in[SAMPLE_BITS-1], samples.left_in};
		rin_ext   = {samples.right_in[SAMPLE_BITS-1], samples.right_in};
		case (op_q)
			sfpg_pkg::OP_GAIN_L: op_gain = gain_q;
			sfpg_pkg::OP_GAIN_R: op_gain = gain_q;
			sfpg_pkg::OP_PAN:    op_gain = pan_gain;
			sfpg_pkg::OP_BOOST:  op_gain = factor_q;
			default:             op_gain = gain_q;
		endcase
	end

	// operation order
	always_comb begin
		op_next  = op_q;
		after_op = sfpg_pkg::S_OUT;
		case (op_q)
			sfpg_pkg::OP_GAIN_L: begin
				op_next  = sfpg_pkg::OP_GAIN_R;
				after_op = sfpg_pkg::S_MUL;
			end
			sfpg_pkg::OP_GAIN_R: begin
				if (pan_q != '0) begin
					op_next  = sfpg_pkg::OP_PAN;
					after_op = sfpg_pkg::S_MUL;
				end else if (soft_mode) begin
					op_next  = sfpg_pkg::OP_BOOST;
					after_op = sfpg_pkg::S_FMUL;
				end
			end
			sfpg_pkg::OP_PAN: begin
				if (soft_mode) begin
					op_next  = sfpg_pkg::OP_BOOST;
					after_op = sfpg_pkg::S_FMUL;
				end
			end
			default: begin
				after_op = sfpg_pkg::S_OUT;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sfpg_pkg::S_IDLE: begin
				if (in_xfer && !stopped_q) begin
					state_d = ramp_step ? sfpg_pkg::S_RMUL : sfpg_pkg::S_MUL;
				end
			end
			sfpg_pkg::S_RMUL:  state_d = sfpg_pkg::S_RDIV;
			sfpg_pkg::S_RDIV:  state_d = sfpg_pkg::S_RWAIT;
			sfpg_pkg::S_RWAIT: if (div_done) state_d = sfpg_pkg::S_MUL;
			sfpg_pkg::S_MUL:   state_d = sfpg_pkg::S_MRES;
			sfpg_pkg::S_MRES:  state_d = curve_need ? sfpg_pkg::S_CMUL : after_op;
			sfpg_pkg::S_CMUL:  state_d = sfpg_pkg::S_CRES;
			sfpg_pkg::S_CRES:  state_d = after_op;
			sfpg_pkg::S_FMUL:  state_d = sfpg_pkg::S_FRES;
			sfpg_pkg::S_FRES:  state_d = sfpg_pkg::S_MUL;
			sfpg_pkg::S_OUT:   if (out_free) state_d = sfpg_pkg::S_IDLE;
			default:           state_d = sfpg_pkg::S_IDLE;
		endcase
	end

	// unit control
	always_comb begin
		samples.ready = (state_q == sfpg_pkg::S_IDLE);
		div_start     = 1'b0;
		div_dividend  = '0;
		div_divisor   = rtotal_q;
		mul_a         = AW'(cur_m);
		mul_b         = BW'(op_gain);
		mul_round     = 1'b1;
		case (state_q)
			sfpg_pkg::S_RMUL: begin
				mul_a     = AW'(ramp_done);
				mul_b     = BW'(ramp_diff);
				mul_round = 1'b0;
			end
			sfpg_pkg::S_RDIV: begin
				div_start    = 1'b1;
				div_dividend = DDW'(mul_p);
				div_divisor  = rtotal_q;
			end
			sfpg_pkg::S_CMUL: begin
				mul_a     = AW'(cur_m - THRESH);
				mul_b     = CURVE_RECIP;
				mul_round = 1'b0;
			end
			sfpg_pkg::S_FMUL: begin
				mul_a     = AW'(boost_num >> 1);
				mul_b     = BOOST_MULT;
				mul_round = 1'b0;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sfpg_pkg::S_IDLE;
			op_q       <= sfpg_pkg::OP_GAIN_L;
			pan_q      <= '0;
			nsc_q      <= 1'b0;
			fade_tgt_q <= '0;
			term_set_q <= 1'b0;
			gain_q     <= sfpg_pkg::UNITY_GAIN;
			rstart_q   <= '0;
			rtarget_q  <= '0;
			rtotal_q   <= '0;
			rremain_q  <= '0;
			ractive_q  <= 1'b0;
			rterm_q    <= 1'b0;
			stopped_q  <= 1'b0;
			lneg_q     <= 1'b0;
			rneg_q     <= 1'b0;
			lm_q       <= '0;
			rm_q       <= '0;
			last_q     <= 1'b0;
			factor_q   <= '0;
			oval_q     <= 1'b0;
			oleft_q    <= '0;
			oright_q   <= '0;
			olast_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (results.valid && results.ready) oval_q <= 1'b0;

			case (state_q)
				sfpg_pkg::S_IDLE: begin
					if (in_xfer && !stopped_q) begin
						lneg_q <= samples.left_in[SAMPLE_BITS-1];
						rneg_q <= samples.right_in[SAMPLE_BITS-1];
						lm_q   <= samples.left_in[SAMPLE_BITS-1] ? (~lin_ext + MW'(1)) : lin_ext;
						rm_q   <= samples.right_in[SAMPLE_BITS-1] ? (~rin_ext + MW'(1)) : rin_ext;
						op_q   <= sfpg_pkg::OP_GAIN_L;
						last_q <= 1'b0;
						if (ramp_end) begin
							gain_q    <= rtarget_q;
							ractive_q <= 1'b0;
							rtotal_q  <= '0;
							rremain_q <= '0;
							if (rterm_q) begin
								last_q    <= 1'b1;
								stopped_q <= 1'b1;
							end
						end
					end
				end
				sfpg_pkg::S_RWAIT: begin
					if (div_done) begin
						gain_q    <= ramp_up ? (rstart_q + div_quot[GW-1:0])
							: (rstart_q - div_quot[GW-1:0]);
						rremain_q <= rremain_q - RB'(1);
					end
				end
				sfpg_pkg::S_MRES: begin
					if (op_left) lm_q <= m_res;
					else rm_q <= m_res;
					if (!curve_need) op_q <= op_next;
				end
				sfpg_pkg::S_CRES: begin
					if (op_left) lm_q <= lm_q + curve_q;
					else rm_q <= rm_q + curve_q;
					op_q <= op_next;
				end
				sfpg_pkg::S_FRES: begin
					factor_q <= factor_d;
				end
				sfpg_pkg::S_OUT: begin
					if (out_free) begin
						oval_q   <= 1'b1;
						oleft_q  <= saturate(lneg_q, lm_q);
						oright_q <= saturate(rneg_q, rm_q);
						olast_q  <= last_q;
					end
				end
				default: begin
					op_q <= op_q;
				end
			endcase

			if (wr_en) begin
				case (sfpg_pkg::cfg_reg_t'(wr_index))
					sfpg_pkg::REG_GAIN: begin
						gain_q    <= sfpg_pkg::clamp_gain(wr_data[GW-1:0], nsc_q);
						ractive_q <= 1'b0;
						rtotal_q  <= '0;
						rremain_q <= '0;
					end
					sfpg_pkg::REG_PAN: begin
						if ($signed(wr_data[sfpg_pkg::PAN_W-1:0]) < -16'sd16384)
							pan_q <= -16'sd16384;
						else if ($signed(wr_data[sfpg_pkg::PAN_W-1:0]) > 16'sd16384)
							pan_q <= 16'sd16384;
						else
							pan_q <= $signed(wr_data[sfpg_pkg::PAN_W-1:0]);
					end
					sfpg_pkg::REG_NO_SOFT_CLIP: begin
						nsc_q <= wr_data[0];
					end
					sfpg_pkg::REG_FADE_SAMPLES: begin
						if (fade_len == '0) begin
							ractive_q <= 1'b0;
							rtotal_q  <= '0;
							rremain_q <= '0;
						end else begin
							rstart_q  <= gain_q;
							rtarget_q <= sfpg_pkg::clamp_gain(fade_tgt_q, nsc_q);
							rterm_q   <= term_set_q;
							rtotal_q  <= fade_len;
							rremain_q <= fade_len;
							ractive_q <= 1'b1;
						end
					end
					sfpg_pkg::REG_FADE_TARGET: begin
						fade_tgt_q <= wr_data[GW-1:0];
					end
					sfpg_pkg::REG_TERMINATE: begin
						term_set_q <= wr_data[0];
					end
					default: begin
						term_set_q <= term_set_q;
					end
				endcase
			end
		end
	end

	assign results.valid     = oval_q;
	assign results.left_out  = oleft_q;
	assign results.right_out = oright_q;
	assign results.last      = olast_q;

endmodule
